// File: hdl/adspn_pkg.sv
`default_nettype none

package adspn_pkg;

   // address and nonce geometry
   localparam int AddrWidth  = 16;
   localparam int NonceWidth = 64;
   localparam int NumRounds  = 2;

   // stream and register port widths
   localparam int DataWidth = 16;
   localparam int CsrWidth  = 64;

   localparam int HalfWidth   = AddrWidth / 2;
   localparam int WholeNibs   = AddrWidth / 4;
   localparam int KeyBase     = NonceWidth - AddrWidth;
   localparam int NibbleWidth = 4;

   typedef logic [AddrWidth-1:0]   addr_type;
   typedef logic [DataWidth-1:0]   data_type;
   typedef logic [CsrWidth-1:0]    csr_type;
   typedef logic [NibbleWidth-1:0] nibble_type;

   // 4-bit substitution box
   localparam nibble_type SboxTable [16] = '{
      4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
      4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
   };

   // round key from the top address-width bits of the nonce
   function automatic addr_type key_from_nonce(csr_type nonce);
      addr_type k;
      k = '0;
      for (int i = 0; i < AddrWidth; i++) begin
         if (KeyBase + i >= 0) begin
            k[i] = nonce[KeyBase + i];
         end
      end
      return k;
   endfunction

   // sbox on every whole nibble, leftover top bits pass through
   function automatic addr_type subst_layer(addr_type v);
      addr_type r;
      r = v;
      for (int n = 0; n < WholeNibs; n++) begin
         r[NibbleWidth*n +: NibbleWidth] = SboxTable[v[NibbleWidth*n +: NibbleWidth]];
      end
      return r;
   endfunction

   // bit order reversal across the address
   function automatic addr_type reverse_layer(addr_type v);
      addr_type r;
      for (int i = 0; i < AddrWidth; i++) begin
         r[AddrWidth-1-i] = v[i];
      end
      return r;
   endfunction

   // even bits to lower half, odd bits to upper half, odd top bit stays
   function automatic addr_type butterfly_layer(addr_type v);
      addr_type r;
      r = v;
      for (int i = 0; i < HalfWidth; i++) begin
         r[i]             = v[2*i];
         r[i + HalfWidth] = v[2*i + 1];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hdl/address_spn_scrambler_core.sv
// address scrambler, one address in and one scrambled address out per item
//
// req_ channel carries the plain address in req_tdata, rsp_ channel returns
// the scrambled address in rsp_tdata, zero extended to the data width.
// csr_we with csr_wdata loads the nonce; its top address-width bits are the
// round key. write it only while no item is in flight.
//
// an accepted item is loaded into the input register, then into the result
// register, which drives rsp_tvalid and rsp_tdata until rsp_tready takes it.
// throughput: one item per cycle while the receiver does not stall; the
// rounds are fixed wiring plus sbox lookups, so nothing iterates.
//
// reset clears both register valids and sets the key to zero.
// when the receiver stalls, the result register holds and the input register
// still accepts one item; after that req_tready drops until rsp_tready
// returns, and no item is lost.
`default_nettype none

module address_spn_scrambler_core
   import adspn_pkg::*;
(
   input  var logic     clock,
   input  var logic     reset,
   input  var logic     req_tvalid,
   output var logic     req_tready,
   input  var data_type req_tdata,    // [15:0] plain_address
   output var logic     rsp_tvalid,
   input  var logic     rsp_tready,
   output var data_type rsp_tdata,    // [15:0] scrambled_address
   input  var logic     csr_we,
   input  var csr_type  csr_wdata
);

   addr_type key_ff, key_in;
   logic     in_valid_ff, in_valid_in;
   addr_type in_addr_ff, in_addr_in;
   logic     rsp_valid_ff, rsp_valid_in;
   data_type rsp_data_ff, rsp_data_in;
   addr_type result;
   logic     rsp_take;
   logic     req_take;

   // key register
   assign key_in = csr_we ? key_from_nonce(csr_wdata) : key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // pipeline flow control
   assign rsp_take   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || rsp_take;
   assign req_take   = req_tvalid && req_tready;

   // input register
   assign in_valid_in = req_take || (in_valid_ff && !rsp_take);
   assign in_addr_in  = req_take ? addr_type'(req_tdata) : in_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_addr_ff <= in_addr_in;
   end

   // substitution-permutation rounds
   adspn_rounds u_rounds (
      .plain     (in_addr_ff),
      .key       (key_ff),
      .scrambled (result)
   );

   // result register
   assign rsp_valid_in = rsp_take ? in_valid_ff : rsp_valid_ff;
   assign rsp_data_in  = (rsp_take && in_valid_ff) ? data_type'(result) : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   // a loaded input register moves on whenever the result register frees up
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_take |=> rsp_valid_ff)
      else $error("item dropped between input and result register");

   // the result register takes the rounds of the address it was given
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_take |=> rsp_data_ff == $past(data_type'(result)))
      else $error("result register loaded with wrong value");

   // an empty pipeline is always ready to take an item
   assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff && !rsp_valid_ff |-> req_tready)
      else $error("empty pipeline not ready");

   // a stalled result with a waiting item blocks the input side
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input accepted while pipeline full");
`endif

endmodule

`default_nettype wire

// File: hdl/adspn_rounds.sv
`default_nettype none

module adspn_rounds
   import adspn_pkg::*;
(
   input  var addr_type plain,
   input  var addr_type key,
   output var addr_type scrambled
);

   addr_type stage [NumRounds+1];

   // unrolled rounds: key mix, substitution, reversal, butterfly
   always_comb begin
      stage[0] = plain;
      for (int r = 0; r < NumRounds; r++) begin
         stage[r+1] = butterfly_layer(reverse_layer(subst_layer(stage[r] ^ key)));
      end
   end

   // closing key mix
   assign scrambled = stage[NumRounds] ^ key;

endmodule

`default_nettype wire
